### src/ppis_pkg.sv
// Shared types and constants for the PID controller with integral separation.
`default_nettype none

package ppis_pkg;

    // fixed formats
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 8;
    localparam int GAIN_W   = 16;
    localparam int SUM_W    = 32;
    localparam int LIM_W    = 31;
    localparam int THR_W    = 17;
    localparam int DRIVE_W  = 32;

    // derived datapath widths
    localparam int ERR_W  = SAMPLE_W + 1;
    localparam int DIFF_W = SAMPLE_W + 2;
    localparam int CMP_W  = (ERR_W > THR_W) ? ERR_W : THR_W;
    localparam int SSUM_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
    localparam int PP_W   = GAIN_W + ERR_W;
    localparam int PI_W   = GAIN_W + SUM_W;
    localparam int PD_W   = GAIN_W + DIFF_W;
    localparam int PMAX_W = (PI_W > PD_W) ? ((PI_W > PP_W) ? PI_W : PP_W)
                                          : ((PD_W > PP_W) ? PD_W : PP_W);
    localparam int ACC_W  = PMAX_W + 2;
    localparam int Y_W    = ACC_W - FRAC_W;

    // register bus
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_LIMIT    = 3'd4,
        REG_THRESH   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
        logic        [LIM_W-1:0]    limit;
        logic        [THR_W-1:0]    thresh;
    } t_cfg;

    // error stage -> multiply stage
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
        logic                     integ;
    } t_err_stage;

    // multiply stage -> output stage
    typedef struct packed {
        logic signed [PP_W-1:0] prod_p;
        logic signed [PI_W-1:0] prod_i;
        logic signed [PD_W-1:0] prod_d;
        logic                   integ;
    } t_mul_stage;

endpackage

`default_nettype wire

### src/ppis_regs.sv
// Configuration register file with APB-style access.
`default_nettype none

module ppis_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ppis_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ppis_pkg::DATA_W-1:0]  pwdata,
    output logic      [ppis_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output ppis_pkg::t_cfg                    o_cfg
);
    import ppis_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_SETPOINT: n_cfg.setpoint = pwdata[SAMPLE_W-1:0];
                REG_GAIN_P:   n_cfg.gain_p   = pwdata[GAIN_W-1:0];
                REG_GAIN_I:   n_cfg.gain_i   = pwdata[GAIN_W-1:0];
                REG_GAIN_D:   n_cfg.gain_d   = pwdata[GAIN_W-1:0];
                REG_LIMIT:    n_cfg.limit    = pwdata[LIM_W-1:0];
                REG_THRESH:   n_cfg.thresh   = pwdata[THR_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SETPOINT: prdata = DATA_W'(unsigned'(r_cfg.setpoint));
            REG_GAIN_P:   prdata = DATA_W'(unsigned'(r_cfg.gain_p));
            REG_GAIN_I:   prdata = DATA_W'(unsigned'(r_cfg.gain_i));
            REG_GAIN_D:   prdata = DATA_W'(unsigned'(r_cfg.gain_d));
            REG_LIMIT:    prdata = DATA_W'(r_cfg.limit);
            REG_THRESH:   prdata = DATA_W'(r_cfg.thresh);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### src/ppis_err.sv
// Error stage: error, integral separation, clamped integrator and derivative term.
`default_nettype none

module ppis_err (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ppis_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_valid,
    input  wire logic [ppis_pkg::SAMPLE_W-1:0]  i_fb,
    output logic                                o_ready,
    output logic                                o_valid,
    output ppis_pkg::t_err_stage                o_data,
    input  wire logic                           i_ready
);
    import ppis_pkg::*;

    logic                     r_v;
    t_err_stage               r_data;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ERR_W-1:0]  r_prev;

    logic                     w_take;
    logic signed [ERR_W-1:0]  w_err;
    logic        [ERR_W-1:0]  w_mag;
    logic                     w_integ;
    logic signed [SSUM_W-1:0] w_add;
    logic signed [SSUM_W-1:0] w_lim;
    logic signed [SSUM_W-1:0] w_clamp;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DIFF_W-1:0] w_diff;

    assign o_ready = !r_v || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_data  = r_data;

    always_comb begin
        w_err   = ERR_W'($signed(i_cfg.setpoint)) - ERR_W'($signed(i_fb));
        w_mag   = w_err[ERR_W-1] ? unsigned'(-w_err) : unsigned'(w_err);
        w_integ = CMP_W'(w_mag) < CMP_W'(i_cfg.thresh);
        w_add   = SSUM_W'(r_sum) + SSUM_W'(w_err);
        w_lim   = SSUM_W'($signed({1'b0, i_cfg.limit}));
        w_clamp = w_add;
        // upper bound first; a zero limit then pins the sum to zero
        if (w_add >= w_lim) begin
            w_clamp = w_lim;
        end
        if (w_clamp <= -w_lim) begin
            w_clamp = -w_lim;
        end
        n_sum  = w_integ ? w_clamp[SUM_W-1:0] : '0;
        w_diff = DIFF_W'(w_err) - DIFF_W'(r_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_sum  <= '0;
            r_prev <= '0;
        end else begin
            if (w_take) begin
                r_v    <= 1'b1;
                r_sum  <= n_sum;
                r_prev <= w_err;
            end else if (i_ready) begin
                r_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data.err   <= w_err;
            r_data.sum   <= n_sum;
            r_data.diff  <= w_diff;
            r_data.integ <= w_integ;
        end
    end

    a_clear_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && !w_integ |=> r_sum == '0)
        else $error("integrator not cleared outside separation band");

    a_prev_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_prev == $past(w_err) && r_data.sum == r_sum)
        else $error("state and forwarded sum disagree");

    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_integ |=>
            (SSUM_W'(r_sum) <= SSUM_W'($signed({1'b0, $past(i_cfg.limit)})))
            && (SSUM_W'(r_sum) >= -SSUM_W'($signed({1'b0, $past(i_cfg.limit)}))))
        else $error("integrator outside limit");

endmodule

`default_nettype wire

### src/ppis_mul.sv
// Multiply stage: the three gain products.
`default_nettype none

module ppis_mul (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ppis_pkg::t_cfg       i_cfg,
    input  wire logic                 i_valid,
    input  wire ppis_pkg::t_err_stage i_data,
    output logic                      o_ready,
    output logic                      o_valid,
    output ppis_pkg::t_mul_stage      o_data,
    input  wire logic                 i_ready
);
    import ppis_pkg::*;

    logic       r_v;
    t_mul_stage r_data;
    t_mul_stage n_data;
    logic       w_take;

    assign o_ready = !r_v || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_data  = r_data;

    always_comb begin
        n_data.prod_p = PP_W'($signed(i_cfg.gain_p)) * PP_W'($signed(i_data.err));
        n_data.prod_i = PI_W'($signed(i_cfg.gain_i)) * PI_W'($signed(i_data.sum));
        n_data.prod_d = PD_W'($signed(i_cfg.gain_d)) * PD_W'($signed(i_data.diff));
        n_data.integ  = i_data.integ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_take) begin
            r_v <= 1'b1;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

### src/ppis_out.sv
// Output stage: sum of products, fraction shift, 32-bit saturation, result register.
`default_nettype none

module ppis_out (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire ppis_pkg::t_mul_stage          i_data,
    output logic                               o_ready,
    output logic                               o_valid,
    output logic [ppis_pkg::DRIVE_W-1:0]       o_drive,
    output logic                               o_integrating,
    output logic                               o_saturated,
    input  wire logic                          i_stall
);
    import ppis_pkg::*;

    localparam logic signed [Y_W-1:0] Y_MAX =
        {{(Y_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN =
        {{(Y_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

    logic                     r_v;
    logic [DRIVE_W-1:0]       r_drive;
    logic                     r_integ;
    logic                     r_sat;

    logic                     w_take;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [Y_W-1:0]    w_y;
    logic [DRIVE_W-1:0]       n_drive;
    logic                     n_sat;

    assign o_ready       = !r_v || !i_stall;
    assign w_take        = i_valid && o_ready;
    assign o_valid       = r_v;
    assign o_drive       = r_drive;
    assign o_integrating = r_integ;
    assign o_saturated   = r_sat;

    always_comb begin
        w_acc = ACC_W'($signed(i_data.prod_p)) + ACC_W'($signed(i_data.prod_i))
              + ACC_W'($signed(i_data.prod_d));
        // arithmetic shift: floor rounding
        w_y = Y_W'(w_acc >>> FRAC_W);
        if (w_y > Y_MAX) begin
            n_drive = Y_MAX[DRIVE_W-1:0];
            n_sat   = 1'b1;
        end else if (w_y < Y_MIN) begin
            n_drive = Y_MIN[DRIVE_W-1:0];
            n_sat   = 1'b1;
        end else begin
            n_drive = w_y[DRIVE_W-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_take) begin
            r_v <= 1'b1;
        end else if (!i_stall) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_drive <= n_drive;
            r_integ <= i_data.integ;
            r_sat   <= n_sat;
        end
    end

endmodule

`default_nettype wire

### src/positional_pid_integral_separation.sv
// Top level: positional PID controller with integral separation.
//
// Usage
//   Feedback samples come in on i_in_valid / o_in_stall with i_feedback; one
//   result per sample leaves on o_out_valid / i_out_stall with o_drive,
//   o_integrating and o_saturated. A transfer happens on a rising edge with
//   valid high and stall low.
//   Gains, setpoint, integral limit and separation threshold are written over
//   the APB-style port (register i at byte address 4*i) while no sample is
//   in flight; pready is tied high.
//   Pipeline: four register stages (input, error/integrator, products,
//   result).
//   Throughput: one sample per cycle while i_out_stall is low. The integrator
//   and last-error state close their loop inside the error stage, so samples
//   may follow back to back.
//   Stall: each stage fills its bubble; with i_out_stall held, up to four
//   samples are held before o_in_stall rises.
//   Reset (synchronous, active low): valid flags and configuration registers
//   zero, integrator and last error cleared, pipeline empty.
`default_nettype none

module positional_pid_integral_separation (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppis_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ppis_pkg::DATA_W-1:0]   pwdata,
    output logic      [ppis_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    // sample channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ppis_pkg::SAMPLE_W-1:0] i_feedback,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [ppis_pkg::DRIVE_W-1:0]  o_drive,
    output logic                               o_integrating,
    output logic                               o_saturated
);
    import ppis_pkg::*;

    t_cfg                 w_cfg;

    // input register
    logic                 r_in_v;
    logic [SAMPLE_W-1:0]  r_fb;
    logic                 w_in_take;

    // stage links
    logic                 w_err_ready;
    logic                 w_err_valid;
    t_err_stage           w_err_data;
    logic                 w_mul_ready;
    logic                 w_mul_valid;
    t_mul_stage           w_mul_data;
    logic                 w_out_ready;

    ppis_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input register takes a sample whenever it is empty or draining
    assign o_in_stall = r_in_v && !w_err_ready;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_take) begin
            r_in_v <= 1'b1;
        end else if (w_err_ready) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_fb <= i_feedback;
        end
    end

    ppis_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (r_in_v),
        .i_fb    (r_fb),
        .o_ready (w_err_ready),
        .o_valid (w_err_valid),
        .o_data  (w_err_data),
        .i_ready (w_mul_ready)
    );

    ppis_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_err_valid),
        .i_data  (w_err_data),
        .o_ready (w_mul_ready),
        .o_valid (w_mul_valid),
        .o_data  (w_mul_data),
        .i_ready (w_out_ready)
    );

    ppis_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_mul_valid),
        .i_data        (w_mul_data),
        .o_ready       (w_out_ready),
        .o_valid       (o_out_valid),
        .o_drive       (o_drive),
        .o_integrating (o_integrating),
        .o_saturated   (o_saturated),
        .i_stall       (i_out_stall)
    );

endmodule

`default_nettype wire
